// ===== src/bmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Bulk message reassembler package
// Shared item codes, receiver states and the result record of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmr_pkg;

    // Item commands.
    typedef enum logic [1:0] {
        CMD_FIRST  = 2'd0,
        CMD_CONSEC = 2'd1,
        CMD_RESET  = 2'd2
    } cmd_t;

    // Frame status codes as reported at frame end.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ERROR      = 2'd1,
        ST_BAD_LENGTH = 2'd2
    } status_t;

    // Receiver state codes as reported on receiver_state.
    localparam logic [1:0] RS_IDLE      = 2'd0;
    localparam logic [1:0] RS_RECEIVING = 2'd1;
    localparam logic [1:0] RS_COMPLETE  = 2'd2;
    localparam logic [1:0] RS_ERROR     = 2'd3;

    // Receiver state machine, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE      = 4'b0001,
        MODE_RECEIVING = 4'b0010,
        MODE_COMPLETE  = 4'b0100,
        MODE_ERROR     = 4'b1000
    } mode_t;

    // Frame byte positions.
    localparam logic [7:0] POS_KIND      = 8'd1;
    localparam logic [7:0] POS_LEN_FIRST = 8'd2;
    localparam logic [7:0] POS_LEN_LAST  = 8'd5;
    localparam logic [7:0] HEADER_BYTES  = 8'd6;
    localparam logic [7:0] CONSEC_HEADER = 8'd2;
    localparam logic [7:0] POS_MAX       = 8'hFF;
    localparam logic [7:0] SEQ_FIRST     = 8'd1;

    // One result record.
    typedef struct packed {
        logic        data_valid;
        logic [7:0]  out_byte;
        logic [31:0] message_offset;
        logic        message_start;
        logic        frame_done;
        logic [1:0]  frame_status;
        logic        flow_control_request;
        logic [1:0]  receiver_state;
        logic [7:0]  payload_kind;
        logic [31:0] message_length;
    } result_t;

endpackage

`default_nettype wire

// ===== src/bmr_core.sv =====
// ----------------------------------------------------------------------------
// Bulk message reassembler core
// Receiver state and the combinational decode of one frame byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bmr_core
    import bmr_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  cmd,
    input  wire logic        has_byte,
    input  wire logic [7:0]  in_byte,
    input  wire logic        frame_end,
    output result_t          result
);

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    mode_t                  rx_mode_reg,        rx_mode_next;
    logic [7:0]             byte_position_reg,  byte_position_next;
    logic                   seq_error_reg,      seq_error_next;
    logic                   frame_skipped_reg,  frame_skipped_next;
    logic [7:0]             pending_kind_reg,   pending_kind_next;
    logic [31:0]            pending_length_reg, pending_length_next;
    logic [7:0]             kind_held_reg,      kind_held_next;
    logic [LENGTH_BITS-1:0] length_held_reg,    length_held_next;
    logic [LENGTH_BITS-1:0] bytes_received_reg, bytes_received_next;
    logic [7:0]             next_sequence_reg,  next_sequence_next;

    logic                   is_first;
    logic                   is_consec;
    logic [7:0]             pos;
    logic [1:0]             lane;
    logic [LENGTH_BITS-1:0] cap_pending_cur;
    logic [LENGTH_BITS-1:0] cap_pending_new;
    logic [1:0]             state_code;

    // Saturate a decoded length to the width of the length counters.
    function automatic logic [LENGTH_BITS-1:0] cap_length(input logic [31:0] v);
        logic [LENGTH_BITS-1:0] r;
        if ({1'b0, v} > LEN_MAX)
        begin
            r = '1;
        end
        else
        begin
            r = v[LENGTH_BITS-1:0];
        end
        return r;
    endfunction

    assign is_first        = (cmd == CMD_FIRST);
    assign is_consec       = (cmd == CMD_CONSEC);
    assign pos             = byte_position_reg;
    assign lane            = 2'(pos - POS_LEN_FIRST);
    assign cap_pending_cur = cap_length(pending_length_reg);
    assign cap_pending_new = cap_length(pending_length_next);

    always_comb
    begin
        rx_mode_next        = rx_mode_reg;
        byte_position_next  = byte_position_reg;
        seq_error_next      = seq_error_reg;
        frame_skipped_next  = frame_skipped_reg;
        pending_kind_next   = pending_kind_reg;
        pending_length_next = pending_length_reg;
        kind_held_next      = kind_held_reg;
        length_held_next    = length_held_reg;
        bytes_received_next = bytes_received_reg;
        next_sequence_next  = next_sequence_reg;

        result.data_valid           = 1'b0;
        result.out_byte             = 8'd0;
        result.message_offset       = 32'd0;
        result.message_start        = 1'b0;
        result.frame_done           = 1'b0;
        result.frame_status         = ST_OK;
        result.flow_control_request = 1'b0;

        if (cmd == CMD_RESET)
        begin
            rx_mode_next        = MODE_IDLE;
            byte_position_next  = 8'd0;
            seq_error_next      = 1'b0;
            frame_skipped_next  = 1'b0;
            pending_kind_next   = 8'd0;
            pending_length_next = 32'd0;
            kind_held_next      = 8'd0;
            length_held_next    = '0;
            bytes_received_next = '0;
            next_sequence_next  = SEQ_FIRST;
        end
        else if (is_first || is_consec)
        begin
            if (is_consec && rx_mode_reg != MODE_RECEIVING)
            begin
                frame_skipped_next = 1'b1;
            end

            if (has_byte)
            begin
                if (pos != POS_MAX)
                begin
                    byte_position_next = pos + 8'd1;
                end

                if (is_first)
                begin
                    if (pos == POS_KIND)
                    begin
                        pending_kind_next = in_byte;
                    end
                    else if (pos >= POS_LEN_FIRST && pos <= POS_LEN_LAST)
                    begin
                        pending_length_next[8*lane +: 8] = in_byte;
                        if (pos == POS_LEN_LAST)
                        begin
                            result.message_start = 1'b1;
                            bytes_received_next  = '0;
                        end
                    end
                    else if (pos >= HEADER_BYTES && bytes_received_reg < cap_pending_cur)
                    begin
                        result.data_valid     = 1'b1;
                        result.out_byte       = in_byte;
                        result.message_offset = 32'(bytes_received_reg);
                        bytes_received_next   = bytes_received_reg + LENGTH_BITS'(1);
                    end
                end
                else if (!frame_skipped_next)
                begin
                    if (pos == POS_KIND)
                    begin
                        if (in_byte != next_sequence_reg)
                        begin
                            seq_error_next = 1'b1;
                        end
                    end
                    else if (pos >= CONSEC_HEADER && !seq_error_reg &&
                             bytes_received_reg < length_held_reg)
                    begin
                        result.data_valid     = 1'b1;
                        result.out_byte       = in_byte;
                        result.message_offset = 32'(bytes_received_reg);
                        bytes_received_next   = bytes_received_reg + LENGTH_BITS'(1);
                    end
                end
            end

            if (frame_end)
            begin
                result.frame_done = 1'b1;
                if (is_first)
                begin
                    if (byte_position_next < HEADER_BYTES)
                    begin
                        rx_mode_next        = MODE_ERROR;
                        result.frame_status = ST_BAD_LENGTH;
                    end
                    else
                    begin
                        kind_held_next     = pending_kind_next;
                        length_held_next   = cap_pending_new;
                        next_sequence_next = SEQ_FIRST;
                        if (bytes_received_next >= cap_pending_new)
                        begin
                            rx_mode_next = MODE_COMPLETE;
                        end
                        else
                        begin
                            rx_mode_next                = MODE_RECEIVING;
                            result.flow_control_request = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (frame_skipped_next)
                    begin
                        result.frame_status = ST_ERROR;
                    end
                    else if (byte_position_next < CONSEC_HEADER)
                    begin
                        rx_mode_next        = MODE_ERROR;
                        result.frame_status = ST_BAD_LENGTH;
                    end
                    else if (seq_error_next)
                    begin
                        rx_mode_next        = MODE_ERROR;
                        result.frame_status = ST_ERROR;
                    end
                    else
                    begin
                        next_sequence_next = next_sequence_reg + 8'd1;
                        if (bytes_received_next >= length_held_reg)
                        begin
                            rx_mode_next = MODE_COMPLETE;
                        end
                    end
                end
                // Every frame end starts the next frame from scratch.
                byte_position_next = 8'd0;
                seq_error_next     = 1'b0;
                frame_skipped_next = 1'b0;
            end
        end

        result.receiver_state = state_code;
        result.payload_kind   = kind_held_next;
        result.message_length = 32'(length_held_next);
    end

    always_comb
    begin
        unique case (rx_mode_next)
            MODE_IDLE:      state_code = RS_IDLE;
            MODE_RECEIVING: state_code = RS_RECEIVING;
            MODE_COMPLETE:  state_code = RS_COMPLETE;
            MODE_ERROR:     state_code = RS_ERROR;
            default:        state_code = RS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_mode_reg        <= MODE_IDLE;
            byte_position_reg  <= 8'd0;
            seq_error_reg      <= 1'b0;
            frame_skipped_reg  <= 1'b0;
            pending_kind_reg   <= 8'd0;
            pending_length_reg <= 32'd0;
            kind_held_reg      <= 8'd0;
            length_held_reg    <= '0;
            bytes_received_reg <= '0;
            next_sequence_reg  <= SEQ_FIRST;
        end
        else if (accept)
        begin
            rx_mode_reg        <= rx_mode_next;
            byte_position_reg  <= byte_position_next;
            seq_error_reg      <= seq_error_next;
            frame_skipped_reg  <= frame_skipped_next;
            pending_kind_reg   <= pending_kind_next;
            pending_length_reg <= pending_length_next;
            kind_held_reg      <= kind_held_next;
            length_held_reg    <= length_held_next;
            bytes_received_reg <= bytes_received_next;
            next_sequence_reg  <= next_sequence_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/bulk_message_reassembler_top.sv =====
// ----------------------------------------------------------------------------
// Bulk message reassembler
// Receives segmented message frames one frame byte per transfer, checks
// headers and sequence numbers, and emits message bytes with their offsets.
//
// Usage:
//   The item channel (item_valid/item_stall) carries one frame byte, an
//   empty frame end, or a receiver reset per transfer. The result channel
//   (result_valid/result_stall) returns exactly one result per item.
//   The result of an item is registered and presented at the output from
//   the next cycle on. Throughput is one item per cycle while the receiver
//   does not stall; it is set by the single output register, which is reloaded
//   in the same cycle its contents are taken.
//   When the receiver stalls with a result pending, item_stall rises in the
//   same cycle and no item is taken until the result is transferred.
//   Asynchronous reset puts the receiver in the idle state with the held
//   header cleared and the expected sequence number at one; the output
//   register is empty after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bulk_message_reassembler_top
    import bmr_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic        has_byte,
    input  wire logic [7:0]  in_byte,
    input  wire logic        frame_end,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             data_valid,
    output logic [7:0]       out_byte,
    output logic [31:0]      message_offset,
    output logic             message_start,
    output logic             frame_done,
    output logic [1:0]       frame_status,
    output logic             flow_control_request,
    output logic [1:0]       receiver_state,
    output logic [7:0]       payload_kind,
    output logic [31:0]      message_length
);

    logic    accept;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;

    // The input is held off only while a finished result waits and the
    // receiver is stalling; otherwise the output register frees this cycle.
    assign item_stall = result_valid_reg & result_stall;
    assign accept     = item_valid & ~item_stall;

    bmr_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd),
        .has_byte  (has_byte),
        .in_byte   (in_byte),
        .frame_end (frame_end),
        .result    (core_result)
    );

    always_comb
    begin
        if (accept)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            result_valid_next = result_valid_reg;
        end
        else
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // The result payload is loaded only when a new item is taken, so a
    // stalled result stays unchanged.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid         = result_valid_reg;
    assign data_valid           = result_reg.data_valid;
    assign out_byte             = result_reg.out_byte;
    assign message_offset       = result_reg.message_offset;
    assign message_start        = result_reg.message_start;
    assign frame_done           = result_reg.frame_done;
    assign frame_status         = result_reg.frame_status;
    assign flow_control_request = result_reg.flow_control_request;
    assign receiver_state       = result_reg.receiver_state;
    assign payload_kind         = result_reg.payload_kind;
    assign message_length       = result_reg.message_length;

endmodule

`default_nettype wire
